@@ hdl/scbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache package
// Shared codes, item types, default parameter values and helper functions.
// ----------------------------------------------------------------------------
package scbc_pkg;

   localparam int GRANULE_BYTES_DEF    = 64;
   localparam int MAX_POOLED_BYTES_DEF = 1024;
   localparam int CLASS_COUNT_DEF      = 16;
   localparam int MAX_PER_CLASS_DEF    = 128;

   localparam int SIZE_W  = 32;
   localparam int ADDR_W  = 48;
   localparam int CNT_W   = 32;
   localparam int TOTAL_W = 12;

   // Depth of the queue between front and back; kept a power of two.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      CMD_ALLOC       = 2'd0,
      CMD_RELEASE     = 2'd1,
      CMD_STATS_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_HIT            = 3'd0,
      ACT_HEAP_ALLOC     = 3'd1,
      ACT_CACHED_RELEASE = 3'd2,
      ACT_HEAP_FREE      = 3'd3,
      ACT_IGNORED        = 3'd4,
      ACT_STATS_RESET    = 3'd5
   } act_type;

   // Work decided by the front part for the back part.
   typedef enum logic [2:0] {
      OP_HEAP_ALLOC   = 3'd0,
      OP_POOL_ALLOC   = 3'd1,
      OP_POOL_RELEASE = 3'd2,
      OP_HEAP_FREE    = 3'd3,
      OP_IGNORE       = 3'd4,
      OP_STATS_CLEAR  = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SIZE_W-1:0]   size;
      logic [ADDR_W-1:0]   addr;
   } item_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      return (value == CNT_MAX) ? value : value + CNT_W'(1);
   endfunction

endpackage

@@ hdl/scbc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache front
// Accepts requests, checks eligibility and computes the size class.
// ----------------------------------------------------------------------------
module scbc_front #(
   parameter int GRANULE_BYTES    = scbc_pkg::GRANULE_BYTES_DEF,
   parameter int MAX_POOLED_BYTES = scbc_pkg::MAX_POOLED_BYTES_DEF,
   parameter int CLASS_COUNT      = scbc_pkg::CLASS_COUNT_DEF,
   parameter int CLS_W            = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_tuser,
   input  logic [79:0]              req_tdata,
   input  logic                     pool_en,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [CLS_W-1:0]         push_cls,
   output scbc_pkg::item_type       push_item
);

   logic [scbc_pkg::SIZE_W-1:0] size;
   logic [scbc_pkg::ADDR_W-1:0] addr;
   logic [CLASS_COUNT-1:0]      above;
   logic                        eligible;

   assign size = req_tdata[scbc_pkg::SIZE_W-1:0];
   assign addr = req_tdata[scbc_pkg::SIZE_W +: scbc_pkg::ADDR_W];

   // Class is the number of granule boundaries the size lies strictly above.
   always_comb begin
      above = '0;
      for (int k = 1; k < CLASS_COUNT; k++) begin
         above[k] = size > 32'(k * GRANULE_BYTES);
      end
   end

   assign eligible = pool_en && (size != '0) && (size <= 32'(MAX_POOLED_BYTES))
                     && (size <= 32'(CLASS_COUNT * GRANULE_BYTES));

   assign push_cls   = CLS_W'($countones(above));
   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

   always_comb begin
      push_item.size = size;
      push_item.addr = addr;
      case (scbc_pkg::cmd_type'(req_tuser))
         scbc_pkg::CMD_ALLOC: begin
            push_item.op = eligible ? scbc_pkg::OP_POOL_ALLOC : scbc_pkg::OP_HEAP_ALLOC;
         end
         scbc_pkg::CMD_RELEASE: begin
            if (addr == '0) begin
               push_item.op = scbc_pkg::OP_IGNORE;
            end else begin
               push_item.op = eligible ? scbc_pkg::OP_POOL_RELEASE : scbc_pkg::OP_HEAP_FREE;
            end
         end
         scbc_pkg::CMD_STATS_CLEAR: begin
            push_item.op = scbc_pkg::OP_STATS_CLEAR;
         end
         default: begin
            push_item.op = scbc_pkg::OP_IGNORE;
         end
      endcase
   end

endmodule

@@ hdl/scbc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache queue
// Small first-in-first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module scbc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = scbc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ hdl/scbc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache back
// Holds class fills, the address stacks and counters; executes each item.
// ----------------------------------------------------------------------------
module scbc_back #(
   parameter int GRANULE_BYTES = scbc_pkg::GRANULE_BYTES_DEF,
   parameter int CLASS_COUNT   = scbc_pkg::CLASS_COUNT_DEF,
   parameter int MAX_PER_CLASS = scbc_pkg::MAX_PER_CLASS_DEF,
   parameter int CLS_W         = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  logic [CLS_W-1:0]               q_cls,
   input  scbc_pkg::item_type             q_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output scbc_pkg::act_type              rsp_action,
   output logic [scbc_pkg::ADDR_W-1:0]    rsp_granted,
   output logic [scbc_pkg::SIZE_W-1:0]    rsp_heap,
   output logic [scbc_pkg::CNT_W-1:0]     rsp_hits,
   output logic [scbc_pkg::CNT_W-1:0]     rsp_misses,
   output logic [scbc_pkg::CNT_W-1:0]     rsp_allocs,
   output logic [scbc_pkg::CNT_W-1:0]     rsp_releases,
   output logic [scbc_pkg::CNT_W-1:0]     rsp_frees,
   output logic [scbc_pkg::TOTAL_W-1:0]   rsp_total
);

   localparam int DEPTH  = CLASS_COUNT * MAX_PER_CLASS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(MAX_PER_CLASS + 1);
   localparam int IDX_W  = (MAX_PER_CLASS > 1) ? $clog2(MAX_PER_CLASS) : 1;
   localparam int CW     = scbc_pkg::CNT_W;
   localparam int TW     = scbc_pkg::TOTAL_W;

   typedef enum logic [1:0] {
      ST_EXEC = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   state_type                   state_ff, state_in;
   logic [FILL_W-1:0]           fill_ff [CLASS_COUNT];
   logic [FILL_W-1:0]           fill_in, fill_cur, mem_idx;
   logic                        fill_we;
   logic [scbc_pkg::ADDR_W-1:0] stack_mem [DEPTH];
   logic [scbc_pkg::ADDR_W-1:0] rd_data_ff;
   logic [AW-1:0]               mem_addr;
   logic                        mem_we, mem_re;
   logic [CW-1:0]               hits_ff, hits_in, misses_ff, misses_in;
   logic [CW-1:0]               allocs_ff, allocs_in, releases_ff, releases_in;
   logic [CW-1:0]               frees_ff, frees_in;
   logic [TW-1:0]               total_ff, total_in;
   logic                        valid_ff, valid_in;
   scbc_pkg::act_type           act_ff, act_in;
   logic [scbc_pkg::ADDR_W-1:0] granted_ff, granted_in;
   logic [scbc_pkg::SIZE_W-1:0] heap_ff, heap_in;
   logic                        slot_free;

   assign fill_cur  = fill_ff[q_cls];
   assign slot_free = !valid_ff || rsp_ready;
   assign mem_addr  = AW'(AW'(q_cls) * AW'(MAX_PER_CLASS)) + AW'(mem_idx[IDX_W-1:0]);

   always_comb begin
      state_in    = state_ff;
      q_ready     = 1'b0;
      fill_we     = 1'b0;
      fill_in     = fill_cur;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_idx     = fill_cur;
      hits_in     = hits_ff;
      misses_in   = misses_ff;
      allocs_in   = allocs_ff;
      releases_in = releases_ff;
      frees_in    = frees_ff;
      total_in    = total_ff;
      valid_in    = valid_ff && !rsp_ready;
      act_in      = act_ff;
      granted_in  = granted_ff;
      heap_in     = heap_ff;
      case (state_ff)
         ST_EXEC: begin
            if (q_valid && slot_free) begin
               q_ready    = 1'b1;
               valid_in   = 1'b1;
               granted_in = '0;
               heap_in    = '0;
               act_in     = scbc_pkg::ACT_IGNORED;
               case (q_item.op)
                  scbc_pkg::OP_HEAP_ALLOC: begin
                     allocs_in = scbc_pkg::sat_inc(allocs_ff);
                     act_in    = scbc_pkg::ACT_HEAP_ALLOC;
                     heap_in   = q_item.size;
                  end
                  scbc_pkg::OP_POOL_ALLOC: begin
                     if (fill_cur != '0) begin
                        // Pop: the address arrives from the stack next cycle.
                        fill_we  = 1'b1;
                        fill_in  = fill_cur - FILL_W'(1);
                        mem_idx  = fill_in;
                        mem_re   = 1'b1;
                        hits_in  = scbc_pkg::sat_inc(hits_ff);
                        total_in = (total_ff != '0) ? total_ff - TW'(1) : total_ff;
                        valid_in = 1'b0;
                        state_in = ST_POP;
                     end else begin
                        misses_in = scbc_pkg::sat_inc(misses_ff);
                        allocs_in = scbc_pkg::sat_inc(allocs_ff);
                        act_in    = scbc_pkg::ACT_HEAP_ALLOC;
                        heap_in   = 32'((32'(q_cls) + 32'd1) * 32'(GRANULE_BYTES));
                     end
                  end
                  scbc_pkg::OP_POOL_RELEASE: begin
                     if (fill_cur < FILL_W'(MAX_PER_CLASS)) begin
                        fill_we     = 1'b1;
                        fill_in     = fill_cur + FILL_W'(1);
                        mem_we      = 1'b1;
                        releases_in = scbc_pkg::sat_inc(releases_ff);
                        total_in    = (total_ff != scbc_pkg::TOTAL_MAX) ?
                                      total_ff + TW'(1) : total_ff;
                        act_in      = scbc_pkg::ACT_CACHED_RELEASE;
                     end else begin
                        frees_in = scbc_pkg::sat_inc(frees_ff);
                        act_in   = scbc_pkg::ACT_HEAP_FREE;
                     end
                  end
                  scbc_pkg::OP_HEAP_FREE: begin
                     frees_in = scbc_pkg::sat_inc(frees_ff);
                     act_in   = scbc_pkg::ACT_HEAP_FREE;
                  end
                  scbc_pkg::OP_STATS_CLEAR: begin
                     hits_in     = '0;
                     misses_in   = '0;
                     allocs_in   = '0;
                     releases_in = '0;
                     frees_in    = '0;
                     act_in      = scbc_pkg::ACT_STATS_RESET;
                  end
                  default: begin
                     act_in = scbc_pkg::ACT_IGNORED;
                  end
               endcase
            end
         end
         ST_POP: begin
            // The result slot is free here: the pop was only started into a free slot.
            valid_in   = 1'b1;
            act_in     = scbc_pkg::ACT_HIT;
            granted_in = rd_data_ff;
            heap_in    = '0;
            state_in   = ST_EXEC;
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_EXEC;
         valid_ff    <= 1'b0;
         hits_ff     <= '0;
         misses_ff   <= '0;
         allocs_ff   <= '0;
         releases_ff <= '0;
         frees_ff    <= '0;
         total_ff    <= '0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            fill_ff[c] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
         allocs_ff   <= allocs_in;
         releases_ff <= releases_in;
         frees_ff    <= frees_in;
         total_ff    <= total_in;
         if (fill_we) begin
            fill_ff[q_cls] <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      granted_ff <= granted_in;
      heap_ff    <= heap_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_addr] <= q_item.addr;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_addr];
      end
   end

   // Counters only move when the result slot is free, so they are shown directly.
   assign rsp_valid    = valid_ff;
   assign rsp_action   = act_ff;
   assign rsp_granted  = granted_ff;
   assign rsp_heap     = heap_ff;
   assign rsp_hits     = hits_ff;
   assign rsp_misses   = misses_ff;
   assign rsp_allocs   = allocs_ff;
   assign rsp_releases = releases_ff;
   assign rsp_frees    = frees_ff;
   assign rsp_total    = total_ff;

endmodule

@@ hdl/size_class_block_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache
// Caches freed block addresses in per-size-class stacks for fast allocation.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req_ stream. req_tuser carries the command
// (allocate, release, clear statistics) and req_tdata the size and address.
// Every request produces exactly one result on the rsp_ stream, with the
// action in rsp_tuser and the granted address, heap size, five saturating
// statistics counters and the cached block total in rsp_tdata.
// The front part classifies each request in the cycle it is accepted and
// places it in a two-entry queue, so requests keep being taken while the
// back part is busy. The back part executes one item at a time: a hit
// passes through an extra pop state because it reads the address stack
// memory, while every other request is finished in the execute state. The
// result of each item is registered before it appears on the rsp_ stream.
// When the receiver stalls, the result holds and the back part waits; the
// queue then fills and req_tready drops. Reset empties every class, clears
// the counters and the queue and enables pooling; no clearing pass is
// needed. The pool enable bit is written through csr_wr_en and csr_wr_data.
// ----------------------------------------------------------------------------
module size_class_block_cache #(
   parameter int GRANULE_BYTES    = scbc_pkg::GRANULE_BYTES_DEF,
   parameter int MAX_POOLED_BYTES = scbc_pkg::MAX_POOLED_BYTES_DEF,
   parameter int CLASS_COUNT      = scbc_pkg::CLASS_COUNT_DEF,
   parameter int MAX_PER_CLASS    = scbc_pkg::MAX_PER_CLASS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration: the pool enable bit.
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   // Request stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // command
   input  logic [79:0]  req_tdata,  // request_size, block_address
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,  // action
   // granted_address, heap_size, hit_count, miss_count, heap_alloc_count,
   // release_count, heap_free_count, cached_total, zero padding
   output logic [255:0] rsp_tdata
);

   localparam int CLS_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int ITEM_W = $bits(scbc_pkg::item_type);
   localparam int Q_W    = CLS_W + ITEM_W;

   logic                         pool_en_ff;
   logic                         push_valid, push_ready;
   logic [CLS_W-1:0]             push_cls;
   scbc_pkg::item_type           push_item;
   logic                         q_valid, q_ready;
   logic [Q_W-1:0]               q_data;
   scbc_pkg::act_type            rsp_action;
   logic [scbc_pkg::ADDR_W-1:0]  rsp_granted;
   logic [scbc_pkg::SIZE_W-1:0]  rsp_heap;
   logic [scbc_pkg::CNT_W-1:0]   rsp_hits, rsp_misses, rsp_allocs, rsp_releases, rsp_frees;
   logic [scbc_pkg::TOTAL_W-1:0] rsp_total;

   // The pool enable register; the user must write it only while the block is idle, as the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         pool_en_ff <= csr_wr_data;
      end
   end

   scbc_front #(
      .GRANULE_BYTES    (GRANULE_BYTES),
      .MAX_POOLED_BYTES (MAX_POOLED_BYTES),
      .CLASS_COUNT      (CLASS_COUNT),
      .CLS_W            (CLS_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pool_en    (pool_en_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cls   (push_cls),
      .push_item  (push_item)
   );

   scbc_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_cls, push_item}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   scbc_back #(
      .GRANULE_BYTES (GRANULE_BYTES),
      .CLASS_COUNT   (CLASS_COUNT),
      .MAX_PER_CLASS (MAX_PER_CLASS),
      .CLS_W         (CLS_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_cls        (q_data[Q_W-1:ITEM_W]),
      .q_item       (scbc_pkg::item_type'(q_data[ITEM_W-1:0])),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_action   (rsp_action),
      .rsp_granted  (rsp_granted),
      .rsp_heap     (rsp_heap),
      .rsp_hits     (rsp_hits),
      .rsp_misses   (rsp_misses),
      .rsp_allocs   (rsp_allocs),
      .rsp_releases (rsp_releases),
      .rsp_frees    (rsp_frees),
      .rsp_total    (rsp_total)
   );

   assign rsp_tuser = rsp_action;
   assign rsp_tdata = {4'b0, rsp_total, rsp_frees, rsp_releases, rsp_allocs,
                       rsp_misses, rsp_hits, rsp_heap, rsp_granted};

endmodule

@@ hdl/scbc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module scbc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [2:0]   rsp_tuser,
   input logic [255:0] rsp_tdata
);

   // A stalled result keeps its contents until transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A statistics clear shows all five counters at zero.
   a_stats_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == scbc_pkg::ACT_STATS_RESET |->
         rsp_tdata[239:80] == '0)
      else $error("counters not cleared by statistics reset");

   // A hit takes nothing from the heap and has been counted.
   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == scbc_pkg::ACT_HIT |->
         rsp_tdata[79:48] == '0 && rsp_tdata[111:80] != '0)
      else $error("inconsistent hit result");

endmodule

bind size_class_block_cache scbc_checker u_scbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/size_class_block_cache_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block cache testbench
// Self-checking bench for the size class block cache. A queue-fed driver
// pushes allocate, release and clear requests into the request stream while
// a monitor takes results with random back-pressure. Every accepted request
// runs through a behavioral copy of the class stacks and counters, and each
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module size_class_block_cache_tb;

   localparam int GRANULE     = scbc_pkg::GRANULE_BYTES_DEF;
   localparam int MAX_POOLED  = scbc_pkg::MAX_POOLED_BYTES_DEF;
   localparam int CLASSES     = scbc_pkg::CLASS_COUNT_DEF;
   localparam int CLASS_DEPTH = scbc_pkg::MAX_PER_CLASS_DEF;

   localparam int SIZE_W  = scbc_pkg::SIZE_W;
   localparam int ADDR_W  = scbc_pkg::ADDR_W;
   localparam int CNT_W   = scbc_pkg::CNT_W;
   localparam int TOTAL_W = scbc_pkg::TOTAL_W;

   // The command encoding leaves one code unused; the block must ignore it.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Roughly six hundred requests are sent in all, even with both sides
   // stalling; this limit leaves a wide margin.
   localparam int CYCLE_LIMIT = 200000;

   // Percentage of cycles in which each side holds off.
   localparam int IDLE_PCT = 15;

   typedef struct {
      logic [1:0]         cmd;
      logic [SIZE_W-1:0]  size;
      logic [ADDR_W-1:0]  addr;
   } req_item_type;

   typedef struct {
      scbc_pkg::act_type   act;
      logic [ADDR_W-1:0]   granted;
      logic [SIZE_W-1:0]   heap;
      logic [CNT_W-1:0]    hits;
      logic [CNT_W-1:0]    misses;
      logic [CNT_W-1:0]    allocs;
      logic [CNT_W-1:0]    releases;
      logic [CNT_W-1:0]    frees;
      logic [TOTAL_W-1:0]  total;
   } rsp_result_type;

   // Every block input has a known value from time zero.
   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          csr_wr_en   = 1'b0;
   logic          csr_wr_data = 1'b0;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [1:0]    req_tuser   = '0;   // command
   logic [79:0]   req_tdata   = '0;   // request_size, block_address
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [2:0]    rsp_tuser;          // action
   // granted_address, heap_size, hit_count, miss_count, heap_alloc_count,
   // release_count, heap_free_count, cached_total, zero padding
   logic [255:0]  rsp_tdata;

   // Requests waiting to be driven, and results still owed by the block.
   req_item_type    req_backlog[$];
   rsp_result_type  owed_results[$];
   req_item_type    cur_req;

   int  error_count = 0;
   int  cycle_count = 0;
   bit  calm        = 1'b0;   // set during a phase that runs with no idling

   // Behavioral copy of the cache state. It starts at the reset values, and
   // reset is applied only once, at the start of the run.
   logic [ADDR_W-1:0]  class_stack [CLASSES][CLASS_DEPTH];
   int                 class_fill  [CLASSES];
   logic [CNT_W-1:0]   hits_cnt     = '0;
   logic [CNT_W-1:0]   misses_cnt   = '0;
   logic [CNT_W-1:0]   allocs_cnt   = '0;
   logic [CNT_W-1:0]   releases_cnt = '0;
   logic [CNT_W-1:0]   frees_cnt    = '0;
   logic [TOTAL_W-1:0] blocks_held  = '0;
   bit                 pool_on      = 1'b1;

   initial begin
      foreach (class_fill[i]) class_fill[i] = 0;
   end

   size_class_block_cache u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] value);
      return (value == '1) ? value : value + CNT_W'(1);
   endfunction

   // Applies one request to the cache copy and returns the result that the
   // block has to produce for it.
   function automatic rsp_result_type apply_request(input req_item_type r);
      rsp_result_type o;
      int             cls;
      o.act     = scbc_pkg::ACT_IGNORED;
      o.granted = '0;
      o.heap    = '0;
      // A class is used only with pooling on and a size of 1 to MAX_POOLED.
      cls = -1;
      if (pool_on && r.size != 0 && r.size <= MAX_POOLED) begin
         cls = (int'(r.size) + GRANULE - 1) / GRANULE - 1;
         if (cls >= CLASSES) cls = -1;
      end
      case (r.cmd)
         scbc_pkg::CMD_ALLOC: begin
            if (cls < 0) begin
               // Not eligible: the heap serves the request at its own size.
               allocs_cnt = count_up(allocs_cnt);
               o.act  = scbc_pkg::ACT_HEAP_ALLOC;
               o.heap = r.size;
            end else if (class_fill[cls] > 0) begin
               class_fill[cls]--;
               o.granted = class_stack[cls][class_fill[cls]];
               if (blocks_held != 0) blocks_held = blocks_held - TOTAL_W'(1);
               hits_cnt = count_up(hits_cnt);
               o.act    = scbc_pkg::ACT_HIT;
            end else begin
               // Empty class: a miss that also goes to the heap at class size.
               misses_cnt = count_up(misses_cnt);
               allocs_cnt = count_up(allocs_cnt);
               o.act  = scbc_pkg::ACT_HEAP_ALLOC;
               o.heap = SIZE_W'((cls + 1) * GRANULE);
            end
         end
         scbc_pkg::CMD_RELEASE: begin
            // A null address is dropped without touching any state.
            if (r.addr != 0) begin
               if (cls >= 0 && class_fill[cls] < CLASS_DEPTH) begin
                  class_stack[cls][class_fill[cls]] = r.addr;
                  class_fill[cls]++;
                  if (blocks_held != scbc_pkg::TOTAL_MAX)
                     blocks_held = blocks_held + TOTAL_W'(1);
                  releases_cnt = count_up(releases_cnt);
                  o.act        = scbc_pkg::ACT_CACHED_RELEASE;
               end else begin
                  frees_cnt = count_up(frees_cnt);
                  o.act     = scbc_pkg::ACT_HEAP_FREE;
               end
            end
         end
         scbc_pkg::CMD_STATS_CLEAR: begin
            // The held-block total and the stacks survive a counter clear.
            hits_cnt     = '0;
            misses_cnt   = '0;
            allocs_cnt   = '0;
            releases_cnt = '0;
            frees_cnt    = '0;
            o.act        = scbc_pkg::ACT_STATS_RESET;
         end
         default: ;
      endcase
      o.hits     = hits_cnt;
      o.misses   = misses_cnt;
      o.allocs   = allocs_cnt;
      o.releases = releases_cnt;
      o.frees    = frees_cnt;
      o.total    = blocks_held;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Request driver. A new item is put on the bus only once the previous one
   // has been taken, so tvalid never drops while an item is waiting. The
   // prediction is made at the edge where the transfer happens.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) owed_results.push_back(apply_request(cur_req));
         if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            cur_req = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cur_req.cmd;
            req_tdata  <= {cur_req.addr, cur_req.size};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor with random back-pressure. Every transfer is checked
   // against the oldest prediction; an extra result is a failure of its own.
   always @(posedge clock) begin : result_check
      rsp_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with no request pending", 64'(rsp_tuser), '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_tuser !== want.act)
                  report_mismatch("action", 64'(rsp_tuser), 64'(want.act));
               if (rsp_tdata[47:0] !== want.granted)
                  report_mismatch("granted_address", 64'(rsp_tdata[47:0]), 64'(want.granted));
               if (rsp_tdata[79:48] !== want.heap)
                  report_mismatch("heap_size", 64'(rsp_tdata[79:48]), 64'(want.heap));
               if (rsp_tdata[111:80] !== want.hits)
                  report_mismatch("hit_count", 64'(rsp_tdata[111:80]), 64'(want.hits));
               if (rsp_tdata[143:112] !== want.misses)
                  report_mismatch("miss_count", 64'(rsp_tdata[143:112]), 64'(want.misses));
               if (rsp_tdata[175:144] !== want.allocs)
                  report_mismatch("heap_alloc_count", 64'(rsp_tdata[175:144]),
                                  64'(want.allocs));
               if (rsp_tdata[207:176] !== want.releases)
                  report_mismatch("release_count", 64'(rsp_tdata[207:176]),
                                  64'(want.releases));
               if (rsp_tdata[239:208] !== want.frees)
                  report_mismatch("heap_free_count", 64'(rsp_tdata[239:208]),
                                  64'(want.frees));
               if (rsp_tdata[251:240] !== want.total)
                  report_mismatch("cached_total", 64'(rsp_tdata[251:240]), 64'(want.total));
               if (rsp_tdata[255:252] !== 4'b0)
                  report_mismatch("padding", 64'(rsp_tdata[255:252]), '0);
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic enqueue(input logic [1:0] cmd, input logic [SIZE_W-1:0] size,
                          input logic [ADDR_W-1:0] addr);
      req_item_type r;
      r.cmd  = cmd;
      r.size = size;
      r.addr = addr;
      req_backlog.push_back(r);
   endtask

   // Waits until every queued request has been taken and every result seen.
   // Each request gives exactly one result, so a short pause then suffices.
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || owed_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The pool enable is only changed while nothing is in flight.
   task automatic write_pool(input bit value);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pool_on      = value;
   endtask

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [ADDR_W-1:0] a;
      a = {16'($urandom), 32'($urandom)};
      if ($urandom_range(0, 99) < 5) a = '0;
      return a;
   endfunction

   // Mostly sizes that land in the given class range, with a share of sizes
   // that are zero, above the pooled limit, fully random or all ones.
   function automatic logic [SIZE_W-1:0] rand_size(input int lo_cls, input int hi_cls);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85)
         return SIZE_W'($urandom_range(lo_cls, hi_cls) * GRANULE + $urandom_range(1, GRANULE));
      else if (roll < 89)
         return '0;
      else if (roll < 93)
         return SIZE_W'(MAX_POOLED + 1 + $urandom_range(0, 3000));
      else if (roll < 97)
         return $urandom;
      return '1;
   endfunction

   task automatic queue_mixed(input int count, input int lo_cls, input int hi_cls);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 42)
            enqueue(scbc_pkg::CMD_ALLOC, rand_size(lo_cls, hi_cls), rand_addr());
         else if (roll < 86)
            enqueue(scbc_pkg::CMD_RELEASE, rand_size(lo_cls, hi_cls), rand_addr());
         else if (roll < 93)
            enqueue(scbc_pkg::CMD_STATS_CLEAR, $urandom, rand_addr());
         else
            enqueue(CMD_UNUSED, $urandom, rand_addr());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with pooling on.
      write_pool(1'b1);
      enqueue(scbc_pkg::CMD_ALLOC,   32'd1,    48'h0);     // miss, smallest class
      enqueue(scbc_pkg::CMD_RELEASE, 32'd64,   48'hFFFF_FFFF_FFFF); // widest address
      enqueue(scbc_pkg::CMD_ALLOC,   32'd64,   48'h0);     // hit returns it
      enqueue(scbc_pkg::CMD_ALLOC,   32'd0,    48'h0);     // zero size goes to heap
      enqueue(scbc_pkg::CMD_ALLOC,   32'd1025, 48'h0);     // just over the pooled limit
      enqueue(scbc_pkg::CMD_ALLOC,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      enqueue(scbc_pkg::CMD_ALLOC,   32'd1024, 48'h0);     // miss in the largest class
      enqueue(scbc_pkg::CMD_RELEASE, 32'd1024, 48'h1);
      enqueue(scbc_pkg::CMD_RELEASE, 32'd1000, 48'h2);
      enqueue(scbc_pkg::CMD_ALLOC,   32'd961,  48'h0);     // last in, first out
      enqueue(scbc_pkg::CMD_RELEASE, 32'd64,   48'h0);     // null release is ignored
      enqueue(scbc_pkg::CMD_RELEASE, 32'd0,    48'h5);     // ineligible release
      enqueue(scbc_pkg::CMD_RELEASE, 32'd1025, 48'h5);
      enqueue(scbc_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      enqueue(CMD_UNUSED,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF); // unknown command
      enqueue(scbc_pkg::CMD_STATS_CLEAR, 32'd0, 48'h0);
      // Back-to-back traffic on one class pushes to and pops from its stack in turn.
      enqueue(scbc_pkg::CMD_ALLOC,   32'd65,   48'h0);
      enqueue(scbc_pkg::CMD_RELEASE, 32'd128,  48'hAAAA_AAAA_AAAA);
      enqueue(scbc_pkg::CMD_ALLOC,   32'd128,  48'h0);
      enqueue(scbc_pkg::CMD_RELEASE, 32'd65,   48'h5555_5555_5555);

      // With pooling off, even eligible requests go to the heap.
      write_pool(1'b0);
      enqueue(scbc_pkg::CMD_ALLOC,   32'd64,   48'h0);
      enqueue(scbc_pkg::CMD_RELEASE, 32'd64,   48'h7);
      enqueue(scbc_pkg::CMD_ALLOC,   32'd1,    48'h0);

      // Random traffic across all classes.
      write_pool(1'b1);
      queue_mixed(100, 0, CLASSES - 1);

      // Fill one class past its depth so releases overflow to the heap, then
      // drain it until allocations miss again. This stretch runs with no
      // idling on either side.
      wait_drained();
      calm = 1'b1;
      repeat (CLASS_DEPTH + 4)
         enqueue(scbc_pkg::CMD_RELEASE, SIZE_W'(3 * GRANULE + $urandom_range(1, GRANULE)),
                 {16'($urandom), 32'($urandom)} | 48'h1);
      repeat (CLASS_DEPTH + 4)
         enqueue(scbc_pkg::CMD_ALLOC, SIZE_W'(3 * GRANULE + $urandom_range(1, GRANULE)),
                 rand_addr());
      wait_drained();
      calm = 1'b0;

      write_pool(1'b0);
      queue_mixed(80, 0, CLASSES - 1);

      // A few classes only, so allocations often find cached blocks.
      write_pool(1'b1);
      queue_mixed(130, 0, 2);

      wait_drained();
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
